// ===== rtl/lifo_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// lifo_block_allocator_macros.svh
// Assertion macros used by the allocator checker file
// ----------------------------------------------------------------------------
`ifndef LIFO_BLOCK_ALLOCATOR_MACROS_SVH
`define LIFO_BLOCK_ALLOCATOR_MACROS_SVH

// concurrent assertion on a clock, disabled while reset is low
`define LBA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lba assertion failed");

// next-cycle implication built on the macro above
`define LBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  `LBA_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

// ===== rtl/lba_pkg.sv =====
// ----------------------------------------------------------------------------
// lba_pkg
// Widths, codes and memory port types of the block allocator
// ----------------------------------------------------------------------------
package lba_pkg;

  // pool geometry
  localparam int MaxBlocks = 256;
  localparam int IdW       = $clog2(MaxBlocks);
  localparam int CntW      = IdW + 1;
  localparam int PoolLimit = (MaxBlocks > 256) ? 256 : MaxBlocks;

  // request codes, code 3 has no meaning
  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_ALL = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_DOUBLE    = 2'd3
  } status_e;

  // free stack memory port
  typedef struct packed {
    logic           we;
    logic [IdW-1:0] waddr;
    logic [IdW-1:0] wdata;
    logic           re;
    logic [IdW-1:0] raddr;
  } stk_port_t;

  // in-use map memory port
  typedef struct packed {
    logic           we;
    logic [IdW-1:0] waddr;
    logic           wdata;
    logic           re;
    logic [IdW-1:0] raddr;
  } map_port_t;

endpackage

// ===== rtl/lba_req_if.sv =====
// ----------------------------------------------------------------------------
// lba_req_if
// Request channel: operation code and block id with valid/ready
// ----------------------------------------------------------------------------
interface lba_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] block_id;

  modport source (output valid, output operation, output block_id, input ready);
  modport sink   (input valid, input operation, input block_id, output ready);
endinterface

// ===== rtl/lba_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lba_rsp_if
// Response channel: status, granted id and free count with valid/ready
// ----------------------------------------------------------------------------
interface lba_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] granted_id;
  logic [8:0] free_count;

  modport source (output valid, output status, output granted_id, output free_count,
                  input ready);
  modport sink   (input valid, input status, input granted_id, input free_count,
                  output ready);
endinterface

// ===== rtl/lifo_block_allocator.sv =====
// A request is accepted and its memory reads issued; it executes once the result
// register is free, which registers the result beat. One request is in flight at a
// time, set by the read-then-write pass on the free stack and in-use map memories;
// free-all is an ordinary request and a pool size write takes effect at its own edge.
// Reset: pool size 256, all ids free; the stack is not swept, a fill mark makes
// entries below it read as the descending refill order and valid bits clear the map.
// ----------------------------------------------------------------------------
// lifo_block_allocator
// Block id pool with a LIFO free stack and an in-use map held in RAM
// ----------------------------------------------------------------------------
module lifo_block_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  lba_req_if.sink    req,
  lba_rsp_if.source  rsp,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i
);
  import lba_pkg::*;

  stk_port_t      stk;
  map_port_t      map;
  logic [IdW-1:0] stk_rdata;
  logic           map_rdata;

  // sequencer and datapath
  lba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .rsp         (rsp),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stk_o       (stk),
    .stk_rdata_i (stk_rdata),
    .map_o       (map),
    .map_rdata_i (map_rdata)
  );

  // free stack storage
  lba_ram #(.AW(IdW), .DW(IdW)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk.we),
    .waddr_i (stk.waddr),
    .wdata_i (stk.wdata),
    .re_i    (stk.re),
    .raddr_i (stk.raddr),
    .rdata_o (stk_rdata)
  );

  // in-use map storage
  lba_ram #(.AW(IdW), .DW(1)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map.we),
    .waddr_i (map.waddr),
    .wdata_i (map.wdata),
    .re_i    (map.re),
    .raddr_i (map.raddr),
    .rdata_o (map_rdata)
  );

endmodule

// ===== rtl/lba_ram.sv =====
// ----------------------------------------------------------------------------
// lba_ram
// Simple dual-port synchronous RAM, one write and one registered read port
// ----------------------------------------------------------------------------
module lba_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lba_ctrl.sv =====
// ----------------------------------------------------------------------------
// lba_ctrl
// Request sequencer: issues memory reads on accept, then checks, updates
// the stack depth and memories and registers the result beat
// ----------------------------------------------------------------------------
module lba_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lba_req_if.sink                     req,
  lba_rsp_if.source                   rsp,
  input  logic                        cfg_we_i,
  input  logic [8:0]                  cfg_wdata_i,
  output lba_pkg::stk_port_t          stk_o,
  input  logic [lba_pkg::IdW-1:0]     stk_rdata_i,
  output lba_pkg::map_port_t          map_o,
  input  logic                        map_rdata_i
);
  import lba_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic                 state_q, state_d;
  logic [CntW-1:0]      pool_q, pool_d;
  logic [CntW-1:0]      depth_q, depth_d;
  logic [CntW-1:0]      clean_q, clean_d;
  logic [MaxBlocks-1:0] valid_q, valid_d;
  logic [1:0]           op_q;
  logic [IdW-1:0]       id_q;
  logic                 rd_clean_q;
  logic [IdW-1:0]       imp_id_q;
  logic                 out_valid_q, out_valid_d;
  logic [1:0]           status_q, status_d;
  logic [IdW-1:0]       granted_q, granted_d;
  logic [CntW-1:0]      count_q, count_d;

  logic                 accept;
  logic                 done;
  logic [CntW-1:0]      depth_m1;
  logic [CntW-1:0]      cfg_sat;
  logic [IdW-1:0]       grant_id;

  // handshake: one item in flight, result register parts the two sides
  assign req.ready = (state_q == StIdle);
  assign accept    = req.valid && req.ready;
  assign done      = (state_q == StExec) && (!out_valid_q || rsp.ready);
  assign depth_m1  = depth_q - CntW'(1);

  // clamp written pool size into 1..limit
  always_comb begin
    cfg_sat = cfg_wdata_i[CntW-1:0];
    if (cfg_wdata_i == '0) begin
      cfg_sat = CntW'(1);
    end else if ({23'd0, cfg_wdata_i} > 32'(PoolLimit)) begin
      cfg_sat = CntW'(PoolLimit);
    end
  end

  // entries below the fill mark still hold their refill value
  assign grant_id = rd_clean_q ? imp_id_q : stk_rdata_i;

  // execute step
  always_comb begin
    state_d     = state_q;
    pool_d      = pool_q;
    depth_d     = depth_q;
    clean_d     = clean_q;
    valid_d     = valid_q;
    status_d    = status_q;
    granted_d   = granted_q;
    count_d     = count_q;
    // reads issued on accept; writes only happen in exec, so no overlap
    stk_o.re    = accept && (req.operation == OP_ALLOC) && (depth_q != '0);
    stk_o.raddr = depth_m1[IdW-1:0];
    map_o.re    = accept && (req.operation == OP_FREE);
    map_o.raddr = req.block_id;
    stk_o.we    = 1'b0;
    stk_o.waddr = depth_q[IdW-1:0];
    stk_o.wdata = id_q;
    map_o.we    = 1'b0;
    map_o.waddr = id_q;
    map_o.wdata = 1'b0;
    out_valid_d = out_valid_q && !rsp.ready;

    if (accept) begin
      state_d = StExec;
    end

    if (cfg_we_i) begin
      pool_d  = cfg_sat;
      depth_d = cfg_sat;
      clean_d = cfg_sat;
      valid_d = '0;
    end

    if (done) begin
      state_d     = StIdle;
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      granted_d   = '0;
      case (op_q)
        OP_ALLOC: begin
          if (depth_q == '0) begin
            status_d = ST_EXHAUSTED;
          end else begin
            granted_d          = grant_id;
            depth_d            = depth_m1;
            map_o.we           = 1'b1;
            map_o.waddr        = grant_id;
            map_o.wdata        = 1'b1;
            valid_d[grant_id]  = 1'b1;
          end
        end
        OP_FREE: begin
          if ({1'b0, id_q} >= pool_q) begin
            status_d = ST_RANGE;
          end else if (!(valid_q[id_q] && map_rdata_i)) begin
            status_d = ST_DOUBLE;
          end else begin
            map_o.we = 1'b1;
            if (depth_q < pool_q) begin
              stk_o.we = 1'b1;
              depth_d  = depth_q + CntW'(1);
              if (depth_q < clean_q) begin
                clean_d = depth_q;
              end
            end
          end
        end
        OP_FREE_ALL: begin
          depth_d = pool_q;
          clean_d = pool_q;
          valid_d = '0;
        end
        default: begin
        end
      endcase
      count_d = depth_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pool_q      <= CntW'(PoolLimit);
      depth_q     <= CntW'(PoolLimit);
      clean_q     <= CntW'(PoolLimit);
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pool_q      <= pool_d;
      depth_q     <= depth_d;
      clean_q     <= clean_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= req.operation;
      id_q       <= req.block_id;
      rd_clean_q <= depth_m1 < clean_q;
      imp_id_q   <= IdW'(pool_q - depth_q);
    end
    status_q  <= status_d;
    granted_q <= granted_d;
    count_q   <= count_d;
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.status     = status_q;
  assign rsp.granted_id = granted_q;
  assign rsp.free_count = count_q;

endmodule

// ===== rtl/lba_checker.sv =====
// ----------------------------------------------------------------------------
// lba_checker
// Port-level checks on the block allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "lifo_block_allocator_macros.svh"

module lba_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [1:0] rsp_status_i,
  input logic [7:0] rsp_granted_i,
  input logic [8:0] rsp_count_i
);
  import lba_pkg::*;

  // a failed request hands out no id
  `LBA_ASSERT(a_err_no_grant, clk_i, rst_ni,
              rsp_valid_i && rsp_status_i != ST_OK |-> rsp_granted_i == '0)

  // exhaustion is only reported on an empty stack
  `LBA_ASSERT(a_exh_empty, clk_i, rst_ni,
              rsp_valid_i && rsp_status_i == ST_EXHAUSTED |-> rsp_count_i == '0)

  // one request in flight: no new beat the cycle after an accept
  `LBA_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // a stalled result beat holds
  `LBA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i,
                   rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_granted_i)
                   && $stable(rsp_count_i))

endmodule

bind lifo_block_allocator lba_checker u_lba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req.valid),
  .req_ready_i   (req.ready),
  .rsp_valid_i   (rsp.valid),
  .rsp_ready_i   (rsp.ready),
  .rsp_status_i  (rsp.status),
  .rsp_granted_i (rsp.granted_id),
  .rsp_count_i   (rsp.free_count)
);
